@@ rtl/mtc_pkg.sv @@
package mtc_pkg;

    // Field widths fixed by the frame format.
    localparam int AXIS_W  = 16;
    localparam int IDX_W   = 6;
    localparam int LEVEL_W = 17;
    localparam int SUM_W   = LEVEL_W + 1;

    // Default record geometry.
    localparam int RECORD_FRAMES_DEF = 64;
    localparam int PRE_FRAMES_DEF    = 39;

    // Trigger level after reset.
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd20480;

    // Source of a result frame during readout.
    localparam logic [1:0] SRC_PRE  = 2'd0;
    localparam logic [1:0] SRC_CAND = 2'd1;
    localparam logic [1:0] SRC_MEM  = 2'd2;

    // One IMU frame as it arrives.
    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
    } t_frame;

    // One frame of a record as it leaves.
    typedef struct packed {
        logic signed [AXIS_W-1:0] out_accel_x;
        logic signed [AXIS_W-1:0] out_accel_y;
        logic signed [AXIS_W-1:0] out_accel_z;
        logic signed [AXIS_W-1:0] out_gyro_x;
        logic signed [AXIS_W-1:0] out_gyro_y;
        logic signed [AXIS_W-1:0] out_gyro_z;
        logic [IDX_W-1:0]         frame_index;
        logic                     last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             shift;
        logic             store;
        logic [IDX_W-1:0] wr_addr;
        logic             rd;
        logic [IDX_W-1:0] rd_addr;
        logic             ld;
        logic             rotate;
        logic [1:0]       src;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trig;
        logic out_free;
    } t_status;

endpackage

@@ rtl/motion_triggered_capture.sv @@
// After the frame that completes a record, each result of the record takes a read
// of the post-trigger store, then a load of the output register, which waits while
// the output register holds a result that has not been taken.
// Throughput: one frame a cycle outside readout; input is held off for the whole
// readout. Reset clears the pretrigger line and the candidate frame, arms the
// trigger and sets the level to 20480.
module motion_triggered_capture #(
    parameter int RECORD_FRAMES = mtc_pkg::RECORD_FRAMES_DEF,
    parameter int PRE_FRAMES    = mtc_pkg::PRE_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mtc_pkg::t_frame             i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mtc_pkg::t_result            o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mtc_pkg::LEVEL_W-1:0] i_cfg_data
);

    localparam int REC_N  = (RECORD_FRAMES > 64) ? 64 :
                            ((RECORD_FRAMES < 2) ? 2 : RECORD_FRAMES);
    localparam int PRE_N  = (PRE_FRAMES < 1) ? 1 :
                            ((PRE_FRAMES >= REC_N) ? REC_N - 1 : PRE_FRAMES);
    localparam int POST_N = REC_N - PRE_N;

    mtc_pkg::t_cmd    w_cmd;
    mtc_pkg::t_status w_status;

    // The level register accepts a request at any time.
    assign o_cfg_ready = 1'b1;

    mtc_ctrl #(
        .PRE_N  (PRE_N),
        .POST_N (POST_N)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mtc_datapath #(
        .PRE_N  (PRE_N),
        .POST_N (POST_N)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

@@ rtl/mtc_ctrl.sv @@
module mtc_ctrl #(
    parameter int PRE_N  = mtc_pkg::PRE_FRAMES_DEF,
    parameter int POST_N = mtc_pkg::RECORD_FRAMES_DEF - mtc_pkg::PRE_FRAMES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtc_pkg::t_status i_status,
    output mtc_pkg::t_cmd  o_cmd
);

    localparam int REC_N = PRE_N + POST_N;
    localparam int CW    = $clog2(POST_N + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;

    logic [1:0]                r_state, n_state;
    logic                      r_capturing, n_capturing;
    logic [CW-1:0]             r_post_count, n_post_count;
    logic [mtc_pkg::IDX_W-1:0] r_k, n_k;
    logic [CW:0]               w_count_inc;
    logic                      w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_count_inc = {1'b0, r_post_count} + (CW+1)'(1);

    // Sequencing of capture and readout.
    always_comb begin
        n_state      = r_state;
        n_capturing  = r_capturing;
        n_post_count = r_post_count;
        n_k          = r_k;
        o_cmd        = '0;
        o_cmd.wr_addr = mtc_pkg::IDX_W'(r_post_count);
        o_cmd.rd_addr = r_k - mtc_pkg::IDX_W'(PRE_N);
        o_cmd.idx     = r_k;
        o_cmd.last    = (r_k == mtc_pkg::IDX_W'(REC_N - 1));
        if (r_k < mtc_pkg::IDX_W'(PRE_N)) begin
            o_cmd.src = mtc_pkg::SRC_PRE;
        end else if (r_k == mtc_pkg::IDX_W'(PRE_N)) begin
            o_cmd.src = mtc_pkg::SRC_CAND;
        end else begin
            o_cmd.src = mtc_pkg::SRC_MEM;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!r_capturing) begin
                        o_cmd.shift = 1'b1;
                        if (i_status.trig) begin
                            if (POST_N == 1) begin
                                n_k     = '0;
                                n_state = ST_RD;
                            end else begin
                                n_capturing  = 1'b1;
                                n_post_count = CW'(1);
                            end
                        end
                    end else begin
                        o_cmd.store = 1'b1;
                        if (w_count_inc >= (CW+1)'(POST_N)) begin
                            n_capturing  = 1'b0;
                            n_post_count = '0;
                            n_k          = '0;
                            n_state      = ST_RD;
                        end else begin
                            n_post_count = w_count_inc[CW-1:0];
                        end
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LD;
            end
            ST_LD: begin
                if (i_status.out_free) begin
                    o_cmd.ld     = 1'b1;
                    o_cmd.rotate = (r_k < mtc_pkg::IDX_W'(PRE_N));
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + mtc_pkg::IDX_W'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_capturing  <= 1'b0;
            r_post_count <= '0;
            r_k          <= '0;
        end else begin
            r_state      <= n_state;
            r_capturing  <= n_capturing;
            r_post_count <= n_post_count;
            r_k          <= n_k;
        end
    end

endmodule

@@ rtl/mtc_datapath.sv @@
module mtc_datapath #(
    parameter int PRE_N  = mtc_pkg::PRE_FRAMES_DEF,
    parameter int POST_N = mtc_pkg::RECORD_FRAMES_DEF - mtc_pkg::PRE_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mtc_pkg::t_frame              i_in_data,
    input  logic                         i_cfg_valid,
    input  logic [mtc_pkg::LEVEL_W-1:0]  i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output mtc_pkg::t_result             o_out_data,
    input  mtc_pkg::t_cmd                i_cmd,
    output mtc_pkg::t_status             o_status
);

    localparam int AW = (POST_N > 1) ? $clog2(POST_N) : 1;

    logic [mtc_pkg::LEVEL_W-1:0] r_level;
    mtc_pkg::t_frame             r_pre [PRE_N];
    mtc_pkg::t_frame             r_cand;
    mtc_pkg::t_frame             r_mem [POST_N];
    mtc_pkg::t_frame             r_rd;
    mtc_pkg::t_frame             w_src;
    mtc_pkg::t_result            r_out;
    logic                        r_out_valid;
    logic [mtc_pkg::LEVEL_W-1:0] w_abs_x, w_abs_y, w_abs_z;
    logic [mtc_pkg::SUM_W-1:0]   w_sum;

    // Magnitude of a raw axis; full-scale negative maps to 32768.
    function automatic logic [mtc_pkg::LEVEL_W-1:0] abs_axis(
        input logic signed [mtc_pkg::AXIS_W-1:0] v
    );
        logic signed [mtc_pkg::LEVEL_W-1:0] ext;
        ext = mtc_pkg::LEVEL_W'(v);
        if (v[mtc_pkg::AXIS_W-1]) begin
            return -ext;
        end
        return ext;
    endfunction

    // Trigger test on the incoming frame.
    assign w_abs_x = abs_axis(i_in_data.accel_x);
    assign w_abs_y = abs_axis(i_in_data.accel_y);
    assign w_abs_z = abs_axis(i_in_data.accel_z);
    assign w_sum   = mtc_pkg::SUM_W'(w_abs_x) + mtc_pkg::SUM_W'(w_abs_y)
                   + mtc_pkg::SUM_W'(w_abs_z);
    assign o_status.trig     = (w_sum > mtc_pkg::SUM_W'(r_level));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Trigger level register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= mtc_pkg::LEVEL_RESET;
        end else if (i_cfg_valid) begin
            r_level <= i_cfg_data;
        end
    end

    // Pretrigger line and candidate frame; the line rotates during readout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRE_N; i++) begin
                r_pre[i] <= '0;
            end
            r_cand <= '0;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < PRE_N - 1; i++) begin
                r_pre[i] <= r_pre[i+1];
            end
            r_pre[PRE_N-1] <= r_cand;
            r_cand         <= i_in_data;
        end else if (i_cmd.rotate) begin
            for (int i = 0; i < PRE_N - 1; i++) begin
                r_pre[i] <= r_pre[i+1];
            end
            r_pre[PRE_N-1] <= r_pre[0];
        end
    end

    // Post-trigger store; entry zero is held in the candidate register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_cmd.wr_addr[AW-1:0]] <= i_in_data;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

    // Frame selection for the next result.
    always_comb begin
        case (i_cmd.src)
            mtc_pkg::SRC_PRE:  w_src = r_pre[0];
            mtc_pkg::SRC_CAND: w_src = r_cand;
            mtc_pkg::SRC_MEM:  w_src = r_rd;
            default:           w_src = r_rd;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_out.out_accel_x <= w_src.accel_x;
            r_out.out_accel_y <= w_src.accel_y;
            r_out.out_accel_z <= w_src.accel_z;
            r_out.out_gyro_x  <= w_src.gyro_x;
            r_out.out_gyro_y  <= w_src.gyro_y;
            r_out.out_gyro_z  <= w_src.gyro_z;
            r_out.frame_index <= i_cmd.idx;
            r_out.last        <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
